FILE: rtl/pba_pkg.sv
// Shared types, constants and helpers of the planar bearing angle block.
`timescale 1ns / 1ps

package pba_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_W   = 2;
    localparam logic [1:0]  REG_REF_X   = 2'd0;
    localparam logic [1:0]  REG_REF_Y   = 2'd1;
    localparam logic [1:0]  REG_HDG_X   = 2'd2;
    localparam logic [1:0]  REG_HDG_Y   = 2'd3;

    // Result field width
    localparam int ANGLE_W = 16;

    // Vector datapath: operands are normalized so the larger one lands at bit NORM_BIT
    localparam int XW       = 62;
    localparam int NORM_BIT = 57;

    // Angle accumulator: degrees with ZFRAC fraction bits
    localparam int ZW        = 30;
    localparam int ZFRAC     = 20;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] DEG90  = ZW'(90) <<< ZFRAC;
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180) <<< ZFRAC;

    // atan(2^-i) in degrees, rounded at the accumulator scale
    localparam logic signed [ZW-1:0] ATAN_DEG [TABLE_LEN] = '{
        ZW'(47185920), ZW'(27855475), ZW'(14718068), ZW'(7471121),
        ZW'(3750058),  ZW'(1876857),  ZW'(938658),   ZW'(469357),
        ZW'(234682),   ZW'(117342),   ZW'(58671),    ZW'(29335),
        ZW'(14668),    ZW'(7334),     ZW'(3667),     ZW'(1833),
        ZW'(917),      ZW'(458),      ZW'(229),      ZW'(115),
        ZW'(57),       ZW'(29),       ZW'(14),       ZW'(7)
    };

    // Vector pair, both components non-negative where it is used
    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
    } t_xy;

    // Side flags that travel with an item through the pipeline
    typedef struct packed {
        logic coincident;
        logic zero;
    } t_flags;

    // Three binary normalization steps of sizes sh0, sh0/2, sh0/4;
    // take a step only while the larger operand stays at or below bit NORM_BIT
    function automatic t_xy norm3(input t_xy v, input int sh0);
        t_xy r;
        int  sh;
        r = v;
        for (int j = 0; j < 3; j++) begin
            sh = sh0 >> j;
            if (((r.x | r.y) >> (NORM_BIT + 1 - sh)) == '0) begin
                r.x = r.x << sh;
                r.y = r.y << sh;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/pba_cordic.sv
// Normalizing front end and vectoring CORDIC pipeline, one iteration per stage.
`timescale 1ns / 1ps

module pba_cordic #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pba_pkg::t_xy                  i_xy,
    input  logic signed [pba_pkg::ZW-1:0] i_z,
    input  pba_pkg::t_flags               i_flags,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [pba_pkg::ZW-1:0] o_z,
    output pba_pkg::t_flags               o_flags
);

    localparam int NIT = (CORDIC_STAGES < pba_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                               : pba_pkg::TABLE_LEN;
    localparam int NS  = NIT + 2;

    logic [NS-1:0]                   r_v;
    logic [NS-1:0]                   n_v;
    logic [NS:0]                     w_en;
    logic signed [pba_pkg::XW-1:0]   r_x [NS];
    logic signed [pba_pkg::XW-1:0]   r_y [NS];
    logic signed [pba_pkg::ZW-1:0]   r_z [NS];
    pba_pkg::t_flags                 r_f [NS];
    pba_pkg::t_xy                    n_a;
    pba_pkg::t_xy                    n_b;

    // A stage loads when it is empty or its successor loads too
    assign w_en[NS] = i_ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = ~r_v[k] | w_en[k+1];
    end

    assign n_v = (w_en[NS-1:0] & {r_v[NS-2:0], i_valid}) | (~w_en[NS-1:0] & r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // Normalize, coarse steps
    always_comb begin
        n_a = pba_pkg::norm3(i_xy, 32);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x[0] <= signed'(n_a.x);
            r_y[0] <= signed'(n_a.y);
            r_z[0] <= i_z;
            r_f[0] <= i_flags;
        end
    end

    // Normalize, fine steps
    always_comb begin
        n_b = pba_pkg::norm3('{x: r_x[0], y: r_y[0]}, 4);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_x[1] <= signed'(n_b.x);
            r_y[1] <= signed'(n_b.y);
            r_z[1] <= r_z[0];
            r_f[1] <= r_f[0];
        end
    end

    // Rotate toward the x axis, one micro-rotation per stage
    for (genvar i = 0; i < NIT; i++) begin : g_iter
        localparam int K = i + 2;
        logic signed [pba_pkg::XW-1:0] n_x;
        logic signed [pba_pkg::XW-1:0] n_y;
        logic signed [pba_pkg::ZW-1:0] n_z;

        always_comb begin
            if (!r_y[K-1][pba_pkg::XW-1]) begin
                n_x = r_x[K-1] + (r_y[K-1] >>> i);
                n_y = r_y[K-1] - (r_x[K-1] >>> i);
                n_z = r_z[K-1] + pba_pkg::ATAN_DEG[i];
            end else begin
                n_x = r_x[K-1] - (r_y[K-1] >>> i);
                n_y = r_y[K-1] + (r_x[K-1] >>> i);
                n_z = r_z[K-1] - pba_pkg::ATAN_DEG[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[K]) begin
                r_x[K] <= n_x;
                r_y[K] <= n_y;
                r_z[K] <= n_z;
                r_f[K] <= r_f[K-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_z     = r_z[NS-1];
    assign o_flags = r_f[NS-1];

endmodule

FILE: rtl/planar_bearing_angle.sv
// Top level: bearing angle of a point from a reference position and heading.
//
//  Channel   Direction  Payload                                   Transfer
//  s_axis    in         tdata: point_x, point_y (low bits first)  tvalid & tready
//  m_axis    out        tdata: angle_deg; tuser: coincident       tvalid & tready
//  cfg       in         index (0..3), data (one register)         valid & ready
//
//  One item per clock while the output is not stalled; the stages, in order:
//  offset, four multipliers, product sums, quadrant fold, two normalize
//  stages, one CORDIC iteration per stage, then clamp and rounding.
//  Reset is synchronous: it empties the pipeline and loads register defaults.
//  Each stage holds while its successor is full and stalled; empty stages
//  keep filling, so input is taken while a result waits at the output.
`timescale 1ns / 1ps

module planar_bearing_angle #(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // point_x [COORD_WIDTH-1:0], point_y above it, zero fill to bytes
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // angle_deg [15:0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [pba_pkg::ANGLE_W-1:0]   o_m_axis_tdata,
    // coincident [0]
    output logic                          o_m_axis_tuser,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pba_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int CW  = COORD_WIDTH;
    localparam int DXW = CW + 1;
    localparam int PW  = 2 * CW + 1;
    localparam int PS  = (2 * CW > 58) ? (2 * CW - 58) : 0;
    localparam int SW  = PW - PS + 1;
    localparam int SH  = pba_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam int ZW  = pba_pkg::ZW;
    localparam int XW  = pba_pkg::XW;

    localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (SH - 1);
    localparam logic [ZW-1:0] ANGLE_MAX  = ZW'(180) << ANGLE_FRAC_BITS;

    // Configuration registers
    logic signed [CW-1:0] r_ref_x;
    logic signed [CW-1:0] r_ref_y;
    logic signed [CW-1:0] r_hdg_x;
    logic signed [CW-1:0] r_hdg_y;

    // Pipeline stages
    logic                 r_v1, r_v2, r_v3, r_v4, r_ov;
    logic                 w_en1, w_en2, w_en3, w_en4, w_en_o;
    logic                 w_cordic_ready;
    logic                 w_cordic_valid;

    logic signed [CW-1:0]  w_px;
    logic signed [CW-1:0]  w_py;
    logic signed [DXW-1:0] r_dx;
    logic signed [DXW-1:0] r_dy;
    logic                  r_coin1, r_coin2, r_coin3;
    logic signed [PW-1:0]  r_pxx, r_pyy, r_pxy, r_pyx;
    logic signed [SW-1:0]  r_dot;
    logic signed [SW-1:0]  r_cross;
    logic signed [XW-1:0]  n_cabs;
    logic signed [XW-1:0]  n_dot;
    pba_pkg::t_xy          n_xy;
    pba_pkg::t_xy          r_xy;
    logic signed [ZW-1:0]  n_z0;
    logic signed [ZW-1:0]  r_z0;
    pba_pkg::t_flags       r_f4;

    logic signed [ZW-1:0]  w_cz;
    pba_pkg::t_flags       w_cf;
    logic signed [ZW-1:0]  n_zsel;
    logic [ZW-1:0]         n_zc;
    logic [ZW-1:0]         n_rnd;
    logic [pba_pkg::ANGLE_W-1:0] n_angle;
    logic [pba_pkg::ANGLE_W-1:0] r_angle;
    logic                  r_coin_o;

    // Write configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_hdg_x <= CW'(1);
            r_hdg_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pba_pkg::REG_REF_X: r_ref_x <= i_cfg_data;
                pba_pkg::REG_REF_Y: r_ref_y <= i_cfg_data;
                pba_pkg::REG_HDG_X: r_hdg_x <= i_cfg_data;
                pba_pkg::REG_HDG_Y: r_hdg_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall chain: a stage loads when it is empty or its successor loads
    assign w_en_o          = ~r_ov | i_m_axis_tready;
    assign w_en4           = ~r_v4 | w_cordic_ready;
    assign w_en3           = ~r_v3 | w_en4;
    assign w_en2           = ~r_v2 | w_en3;
    assign w_en1           = ~r_v1 | w_en2;
    assign o_s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1)  r_v1 <= i_s_axis_tvalid;
            if (w_en2)  r_v2 <= r_v1;
            if (w_en3)  r_v3 <= r_v2;
            if (w_en4)  r_v4 <= r_v3;
            if (w_en_o) r_ov <= w_cordic_valid;
        end
    end

    // Offset from the reference
    assign w_px = i_s_axis_tdata[CW-1:0];
    assign w_py = i_s_axis_tdata[2*CW-1:CW];

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_dx    <= DXW'(w_px) - DXW'(r_ref_x);
            r_dy    <= DXW'(w_py) - DXW'(r_ref_y);
            r_coin1 <= (w_px == r_ref_x) && (w_py == r_ref_y);
        end
    end

    // Heading products
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_pxx   <= PW'(r_hdg_x) * PW'(r_dx);
            r_pyy   <= PW'(r_hdg_y) * PW'(r_dy);
            r_pxy   <= PW'(r_hdg_x) * PW'(r_dy);
            r_pyx   <= PW'(r_hdg_y) * PW'(r_dx);
            r_coin2 <= r_coin1;
        end
    end

    // Dot and cross products
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_dot   <= SW'(r_pxx >>> PS) + SW'(r_pyy >>> PS);
            r_cross <= SW'(r_pxy >>> PS) - SW'(r_pyx >>> PS);
            r_coin3 <= r_coin2;
        end
    end

    // Fold into the right half plane: a backward vector turns by 90 degrees
    always_comb begin
        n_dot  = XW'(r_dot);
        n_cabs = r_cross[SW-1] ? -XW'(r_cross) : XW'(r_cross);
        if (r_dot[SW-1]) begin
            n_xy.x = n_cabs;
            n_xy.y = -n_dot;
            n_z0   = pba_pkg::DEG90;
        end else begin
            n_xy.x = n_dot;
            n_xy.y = n_cabs;
            n_z0   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_xy            <= n_xy;
            r_z0            <= n_z0;
            r_f4.coincident <= r_coin3;
            r_f4.zero       <= (r_dot == '0) && (r_cross == '0);
        end
    end

    pba_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_pba_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (w_cordic_ready),
        .i_xy    (r_xy),
        .i_z     (r_z0),
        .i_flags (r_f4),
        .o_valid (w_cordic_valid),
        .i_ready (w_en_o),
        .o_z     (w_cz),
        .o_flags (w_cf)
    );

    // Clamp, round to the output scale, clamp again; a zero vector reads 90, a coincident point 0
    always_comb begin
        n_zsel = w_cf.zero ? pba_pkg::DEG90 : w_cz;
        if (n_zsel[ZW-1]) begin
            n_zc = '0;
        end else if (n_zsel > pba_pkg::DEG180) begin
            n_zc = ZW'(pba_pkg::DEG180);
        end else begin
            n_zc = ZW'(n_zsel);
        end
        n_rnd = (n_zc + ROUND_HALF) >> SH;
        if (n_rnd > ANGLE_MAX) begin
            n_rnd = ANGLE_MAX;
        end
        n_angle = w_cf.coincident ? '0 : n_rnd[pba_pkg::ANGLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en_o) begin
            r_angle  <= n_angle;
            r_coin_o <= w_cf.coincident;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_angle;
    assign o_m_axis_tuser  = r_coin_o;

endmodule

FILE: rtl/pba_checker.sv
// Port-level checks of the planar bearing angle block, bound to the top level.
`timescale 1ns / 1ps

module pba_checker #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [pba_pkg::ANGLE_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tuser
);

    localparam int   ANGLE_LIM  = 180 << ANGLE_FRAC_BITS;
    localparam logic LIM_WRAPS  = (ANGLE_LIM > 65535);
    localparam logic [pba_pkg::ANGLE_W-1:0] LIM16 = pba_pkg::ANGLE_W'(ANGLE_LIM);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // An empty pipeline takes input
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Coincident point reports angle zero
    a_coin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("coincident item with nonzero angle");

    // Angle never exceeds 180 degrees
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> LIM_WRAPS || (o_m_axis_tdata <= LIM16))
        else $error("angle above 180 degrees");

endmodule

bind planar_bearing_angle pba_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_pba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: sim/planar_bearing_angle_tb.sv
// Self-checking testbench for planar_bearing_angle: directed and random points vs. a predictor.
`timescale 1ns / 1ps

module planar_bearing_angle_tb;

    localparam int CW          = 24;
    localparam int FRAC        = 8;
    localparam int STAGES      = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 220;
    localparam int TAIL_ITEMS  = 200;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;

    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

    localparam longint NORM_TOP  = 64'sd1 <<< pba_pkg::NORM_BIT;
    localparam longint DEG90_L   = 64'sd90 <<< pba_pkg::ZFRAC;
    localparam longint DEG180_L  = 64'sd180 <<< pba_pkg::ZFRAC;
    localparam longint ANGLE_TOP = 64'sd180 <<< FRAC;

    typedef struct packed {
        logic [pba_pkg::ANGLE_W-1:0] angle;
        logic                        coincident;
    } t_bearing;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [2*CW-1:0]               i_s_axis_tdata = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [pba_pkg::ANGLE_W-1:0]   o_m_axis_tdata;
    logic                          o_m_axis_tuser;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [pba_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0]                 i_cfg_data = '0;

    // Register copies kept for prediction
    logic signed [CW-1:0] ref_x_q = '0;
    logic signed [CW-1:0] ref_y_q = '0;
    logic signed [CW-1:0] hdg_x_q = CW'(1);
    logic signed [CW-1:0] hdg_y_q = '0;

    logic [2*CW-1:0] pending_points[$];
    t_bearing        expected_bearings[$];
    int              points_queued = 0;
    int              points_taken = 0;
    int              results_seen = 0;
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              send_gap = 0;
    int              sink_stall = 0;
    int              long_hold_left = 0;
    bit              long_hold_done = 1'b0;
    bit              steady_tail = 1'b0;

    planar_bearing_angle uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // point_x [23:0], point_y [47:24]
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // angle_deg [15:0]
        .o_m_axis_tuser  (o_m_axis_tuser),   // coincident [0]
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Angle of a point seen from the reference, measured off the heading.
    // Products fit in 64 bits at this coordinate width, so no product shift applies.
    function automatic t_bearing predict_bearing(input logic signed [CW-1:0] px,
                                                 input logic signed [CW-1:0] py);
        longint   dx, dy, hx, hy, dot, crs, vx, vy, z, sx, sy, tmp, rnd;
        t_bearing r;
        dx = longint'(px) - longint'(ref_x_q);
        dy = longint'(py) - longint'(ref_y_q);
        hx = longint'(hdg_x_q);
        hy = longint'(hdg_y_q);
        if (dx == 0 && dy == 0) begin
            r.angle      = '0;
            r.coincident = 1'b1;
            return r;
        end
        dot = hx * dx + hy * dy;
        crs = hx * dy - hy * dx;
        if (crs < 0) crs = -crs;
        if (dot == 0 && crs == 0) begin
            z = DEG90_L;
        end else begin
            vx = dot;
            vy = crs;
            z  = 0;
            // Turn a backward vector by a quarter so that 180 comes out exact
            if (vx < 0) begin
                tmp = vx;
                vx  = vy;
                vy  = -tmp;
                z   = DEG90_L;
            end
            while (vx < NORM_TOP && vy < NORM_TOP) begin
                vx = vx <<< 1;
                vy = vy <<< 1;
            end
            // Vectoring iterations drive y toward zero
            for (int i = 0; i < STAGES; i++) begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy >= 0) begin
                    vx = vx + sy;
                    vy = vy - sx;
                    z  = z + longint'(pba_pkg::ATAN_DEG[i]);
                end else begin
                    vx = vx - sy;
                    vy = vy + sx;
                    z  = z - longint'(pba_pkg::ATAN_DEG[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > DEG180_L) z = DEG180_L;
        end
        // Round half up to the output scale
        rnd = (z + (64'sd1 <<< (pba_pkg::ZFRAC - FRAC - 1))) >>> (pba_pkg::ZFRAC - FRAC);
        if (rnd > ANGLE_TOP) rnd = ANGLE_TOP;
        r.angle      = rnd[pba_pkg::ANGLE_W-1:0];
        r.coincident = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s at result %0d: expected %0d, got %0d",
                 what, results_seen, want, got);
        mismatch_count++;
    endtask

    // Track register writes the block accepts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ref_x_q <= '0;
            ref_y_q <= '0;
            hdg_x_q <= CW'(1);
            hdg_y_q <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pba_pkg::REG_REF_X: ref_x_q <= i_cfg_data;
                pba_pkg::REG_REF_Y: ref_y_q <= i_cfg_data;
                pba_pkg::REG_HDG_X: hdg_x_q <= i_cfg_data;
                pba_pkg::REG_HDG_Y: hdg_y_q <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Point driver: predict each item taken, then offer the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            send_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_bearings.push_back(predict_bearing(i_s_axis_tdata[CW-1:0],
                                                            i_s_axis_tdata[2*CW-1:CW]));
                points_taken++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    i_s_axis_tdata  <= pending_points.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    if (!steady_tail && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 18);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off once the stream is under way, so the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_hold_left = 0;
            long_hold_done = 1'b0;
        end else if (!long_hold_done && points_taken >= HOLD_AFTER) begin
            long_hold_left = HOLD_CYCLES;
            long_hold_done = 1'b1;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
        end
    end

    // Result monitor: compare against the oldest prediction, then pick tready
    always @(posedge i_clk) begin
        t_bearing want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (expected_bearings.size() == 0) begin
                    report_mismatch("unexpected result, angle", 0, o_m_axis_tdata);
                end else begin
                    want = expected_bearings.pop_front();
                    if (o_m_axis_tdata !== want.angle)
                        report_mismatch("angle_deg", want.angle, o_m_axis_tdata);
                    if (o_m_axis_tuser !== want.coincident)
                        report_mismatch("coincident", want.coincident, o_m_axis_tuser);
                end
            end
            if (long_hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                i_m_axis_tready <= 1'b0;
            end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
                sink_stall = $urandom_range(0, 17);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("planar_bearing_angle verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [pba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_setup(input logic [CW-1:0] rx, input logic [CW-1:0] ry,
                               input logic [CW-1:0] hx, input logic [CW-1:0] hy);
        write_reg(pba_pkg::REG_REF_X, rx);
        write_reg(pba_pkg::REG_REF_Y, ry);
        write_reg(pba_pkg::REG_HDG_X, hx);
        write_reg(pba_pkg::REG_HDG_Y, hy);
        // let the copies settle before new points arrive
        @(posedge i_clk);
    endtask

    task automatic queue_point(input logic [CW-1:0] px, input logic [CW-1:0] py);
        pending_points.push_back({py, px});
        points_queued++;
    endtask

    // Wait until every queued point has come back as a result
    task automatic drain;
        while (results_seen < points_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random coordinate in half the cases, else an extreme or a small value
    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return CW'($urandom_range(0, 32)) - CW'(16);
            default: return CW'($urandom);
        endcase
    endfunction

    // Random points: mostly arbitrary, some at or near the reference, some along the heading
    task automatic queue_random_points(input int count);
        logic [CW-1:0] px, py;
        int            k;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0: begin
                    px = ref_x_q;
                    py = ref_y_q;
                end
                1, 2: begin
                    px = ref_x_q + CW'($urandom_range(0, 16)) - CW'(8);
                    py = ref_y_q + CW'($urandom_range(0, 16)) - CW'(8);
                end
                3: begin
                    k  = $urandom_range(0, 1) ? $urandom_range(1, 4) : -$urandom_range(1, 4);
                    px = ref_x_q + CW'(k * int'(hdg_x_q));
                    py = ref_y_q + CW'(k * int'(hdg_y_q));
                end
                4: begin
                    px = pick_coord();
                    py = pick_coord();
                end
                default: begin
                    px = CW'($urandom);
                    py = CW'($urandom);
                end
            endcase
            queue_point(px, py);
        end
    endtask

    // Stimulus sequence
    initial begin
        logic [CW-1:0] hx, hy;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset setup: reference at origin, heading along +x
        queue_point(CW'(0), CW'(0));
        queue_point(CW'(1), CW'(0));
        queue_point(-CW'(1), CW'(0));
        queue_point(CW'(0), CW'(1));
        queue_point(CW'(0), -CW'(1));
        queue_point(C_MAX, CW'(0));
        queue_point(C_MIN, CW'(0));
        queue_point(C_MAX, C_MAX);
        queue_point(C_MIN, C_MIN);
        queue_point(C_MAX, C_MIN);
        queue_point(C_MIN, C_MAX);
        queue_point(CW'(1), -CW'(1));
        drain();

        // Extreme reference and heading
        write_setup(C_MAX, C_MIN, C_MIN, C_MAX);
        queue_point(C_MAX, C_MIN);
        queue_point(C_MIN, C_MAX);
        queue_point(C_MAX - CW'(1), C_MIN + CW'(1));
        queue_point(C_MAX, C_MAX);
        queue_point(C_MIN, C_MIN);
        drain();

        // Zero heading gives a right angle except at the reference itself
        write_setup(CW'(0), CW'(0), CW'(0), CW'(0));
        queue_point(CW'(5), CW'(7));
        queue_point(CW'(0), CW'(0));
        queue_point(C_MIN, C_MAX);
        queue_point(C_MAX, C_MIN);
        drain();

        // Heading along -x: points straight behind and straight ahead
        write_setup(CW'(0), CW'(0), C_MIN, CW'(0));
        queue_point(C_MAX, CW'(0));
        queue_point(C_MIN, CW'(0));
        drain();

        // Random setups, each with a burst of random points
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            hx = pick_coord();
            hy = pick_coord();
            if (ph == 2) begin
                hx = CW'($urandom_range(0, 6)) - CW'(3);
                hy = CW'($urandom_range(0, 6)) - CW'(3);
            end
            write_setup(pick_coord(), pick_coord(), hx, hy);
            queue_random_points(PHASE_ITEMS);
            drain();
        end

        // Closing stretch at full rate on both sides
        write_setup(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
        steady_tail = 1'b1;
        queue_random_points(TAIL_ITEMS);
        drain();
        repeat (40) @(posedge i_clk);

        if (expected_bearings.size() != 0)
            report_mismatch("results still missing", 0, expected_bearings.size());
        if (mismatch_count == 0) begin
            $display("planar_bearing_angle verification clean");
        end else begin
            $display("planar_bearing_angle verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pba_pkg.sv
rtl/pba_cordic.sv
rtl/planar_bearing_angle.sv
rtl/pba_checker.sv
sim/planar_bearing_angle_tb.sv
